FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; they expand to nothing for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Consequent that must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`else
`define ASSERT_ALWAYS(name, clk, rst_n, prop, msg)
`define ASSERT_IMPLY(name, clk, rst_n, ante, cons, msg)
`endif
`endif

FILE: sv/tegb_pkg.sv
// ----------------------------------------------------------------------------
// tegb_pkg
// Shared types and constants of the touch event to gamepad converter.
// ----------------------------------------------------------------------------
`default_nettype none

package tegb_pkg;

  // Event types.
  localparam logic [15:0] ModeSync = 16'h0000;
  localparam logic [15:0] ModeKey  = 16'h0001;
  localparam logic [15:0] ModeAbs  = 16'h0003;

  // Event codes.
  localparam logic [15:0] CodeAbsX   = 16'h0000;
  localparam logic [15:0] CodeAbsY   = 16'h0001;
  localparam logic [15:0] CodeMtX    = 16'h0035;
  localparam logic [15:0] CodeMtY    = 16'h0036;
  localparam logic [15:0] CodeTrack  = 16'h0039;
  localparam logic [15:0] CodeTouch  = 16'h014a;

  // Configuration register indexes.
  localparam logic [7:0] CfgXMin = 8'd0;
  localparam logic [7:0] CfgXMax = 8'd1;
  localparam logic [7:0] CfgYMin = 8'd2;
  localparam logic [7:0] CfgYMax = 8'd3;

  // Scaling spans and divider width (largest scaled numerator is below 2^41).
  localparam int unsigned DivW  = 41;
  localparam int          XSpan = 340;
  localparam int          YSpan = 800;

  // Display limits.
  localparam logic [9:0] DispXMax = 10'd799;
  localparam logic [8:0] DispYMax = 9'd339;

  // D-pad box and its dead zone around the center (105, 180).
  localparam logic [9:0] DpadXLo    = 10'd35;
  localparam logic [9:0] DpadXHi    = 10'd175;
  localparam logic [8:0] DpadYLo    = 9'd105;
  localparam logic [8:0] DpadYHi    = 9'd255;
  localparam logic [9:0] DpadLeft   = 10'd83;
  localparam logic [9:0] DpadRight  = 10'd127;
  localparam logic [8:0] DpadUp     = 9'd158;
  localparam logic [8:0] DpadDown   = 9'd202;

  // Pad word bit positions.
  localparam int unsigned PadA      = 0;
  localparam int unsigned PadB      = 1;
  localparam int unsigned PadSelect = 2;
  localparam int unsigned PadStart  = 3;
  localparam int unsigned PadUpB    = 4;
  localparam int unsigned PadDownB  = 5;
  localparam int unsigned PadLeftB  = 6;
  localparam int unsigned PadRightB = 7;

  // Round buttons: center, squared radius and the pad bit they drive.
  typedef struct packed {
    logic [9:0]  cx;
    logic [8:0]  cy;
    logic [11:0] r2;
    logic [2:0]  pos;
  } circle_t;

  localparam circle_t Circles [4] = '{
    '{cx: 10'd720, cy: 9'd150, r2: 12'd2500, pos: 3'(PadA)},
    '{cx: 10'd630, cy: 9'd215, r2: 12'd2500, pos: 3'(PadB)},
    '{cx: 10'd700, cy: 9'd305, r2: 12'd784,  pos: 3'(PadStart)},
    '{cx: 10'd610, cy: 9'd305, r2: 12'd784,  pos: 3'(PadSelect)}
  };

  // Snapshot of the touch state taken at a sync event.
  typedef struct packed {
    logic        active;
    logic [31:0] raw_x;
    logic [31:0] raw_y;
  } job_t;

  // Raw range registers.
  typedef struct packed {
    logic [15:0] x_min;
    logic [15:0] x_max;
    logic [15:0] y_min;
    logic [15:0] y_max;
  } cfg_t;

  // Queue status seen by the front and back ends.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

`default_nettype wire

FILE: sv/tegb_front.sv
// ----------------------------------------------------------------------------
// tegb_front
// Decodes input events, tracks position and finger state, queues sync jobs.
// ----------------------------------------------------------------------------
`default_nettype none

module tegb_front import tegb_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [15:0] mode_i,
  input  wire logic [15:0] event_code_i,
  input  wire logic [31:0] event_value_i,
  input  wire q_stat_t     q_stat_i,
  output logic             push_o,
  output job_t             job_o
);

  logic [31:0] raw_x_q;
  logic [31:0] raw_y_q;
  logic        finger_q;
  logic        accept;

  // Events are held back only while the job queue is full.
  assign in_stall_o = q_stat_i.full;
  assign accept     = in_valid_i && !q_stat_i.full;

  // A sync transaction pushes a snapshot of the current touch state.
  assign push_o        = accept && (mode_i == ModeSync);
  assign job_o.active  = finger_q && !raw_x_q[31];
  assign job_o.raw_x   = raw_x_q;
  assign job_o.raw_y   = raw_y_q;

  // Position and finger state update.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_x_q  <= '1;
      raw_y_q  <= '1;
      finger_q <= 1'b0;
    end else if (accept) begin
      case (mode_i)
        ModeAbs: begin
          if (event_code_i inside {CodeAbsX, CodeMtX}) begin
            raw_x_q <= event_value_i;
          end else if (event_code_i inside {CodeAbsY, CodeMtY}) begin
            raw_y_q <= event_value_i;
          end else if (event_code_i == CodeTrack) begin
            finger_q <= !event_value_i[31];
          end
        end
        ModeKey: begin
          if (event_code_i == CodeTouch) begin
            finger_q <= (event_value_i != '0);
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: sv/tegb_fifo.sv
// ----------------------------------------------------------------------------
// tegb_fifo
// Small register queue between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module tegb_fifo import tegb_pkg::*; #(
  parameter int unsigned Depth = 4,
  parameter int unsigned Width = 65
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             pop_i,
  output logic      [Width-1:0] rdata_o,
  output q_stat_t               stat_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q;
  logic [PtrW-1:0]  rd_ptr_q;
  logic [CntW-1:0]  count_q;
  logic             do_push;
  logic             do_pop;

  assign stat_o.full  = (count_q == CntW'(Depth));
  assign stat_o.empty = (count_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign rdata_o      = mem_q[rd_ptr_q];

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: sv/tegb_div.sv
// ----------------------------------------------------------------------------
// tegb_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tegb_div import tegb_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [DivW-1:0] dividend_i,
  input  wire logic [15:0]     divisor_i,
  output logic                 busy_o,
  output logic      [DivW-1:0] quotient_o
);

  localparam int unsigned CntW = $clog2(DivW + 1);

  logic [CntW-1:0] count_q;
  logic [DivW-1:0] dvd_q;
  logic [DivW-1:0] quo_q;
  logic [15:0]     rem_q;
  logic [15:0]     den_q;
  logic [16:0]     trial;
  logic            fits;

  // Bring down the next dividend bit and try a subtraction.
  assign trial      = {rem_q, dvd_q[DivW-1]};
  assign fits       = (trial >= {1'b0, den_q});
  assign busy_o     = (count_q != '0);
  assign quotient_o = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (start_i) begin
      count_q <= CntW'(DivW);
    end else if (busy_o) begin
      count_q <= count_q - 1'b1;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      den_q <= divisor_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_o) begin
      dvd_q <= {dvd_q[DivW-2:0], 1'b0};
      quo_q <= {quo_q[DivW-2:0], fits};
      rem_q <= fits ? 16'(trial - {1'b0, den_q}) : trial[15:0];
    end
  end

endmodule

`default_nettype wire

FILE: sv/tegb_back.sv
// ----------------------------------------------------------------------------
// tegb_back
// Scales, rotates and clamps a queued touch point and builds the pad word.
// ----------------------------------------------------------------------------
`default_nettype none

module tegb_back import tegb_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire cfg_t        cfg_i,
  input  wire q_stat_t     q_stat_i,
  input  wire job_t        job_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       pad_bits_o,
  output logic [9:0]       disp_x_o,
  output logic [8:0]       disp_y_o,
  output logic             touch_active_o
);

  typedef enum logic [2:0] {
    StIdle, StMul, StDiv, StClamp, StPad, StOut
  } state_e;

  state_e          state_q;
  job_t            job_q;
  logic            neg_x_q;
  logic            neg_y_q;
  logic [9:0]      dx_q;
  logic [8:0]      dy_q;
  logic [7:0]      pad_q;
  logic            act_q;
  logic [1:0]      step_q;

  logic            start;
  logic            scale_x;
  logic            scale_y;
  logic signed [32:0] diff_x;
  logic signed [32:0] diff_y;
  logic signed [42:0] prod_x;
  logic signed [42:0] prod_y;
  logic [DivW-1:0] dvd_x;
  logic [DivW-1:0] dvd_y;
  logic [15:0]     den_x;
  logic [15:0]     den_y;
  logic            neg_x_d;
  logic            neg_y_d;
  logic            busy_x;
  logic            busy_y;
  logic [DivW-1:0] quo_x;
  logic [DivW-1:0] quo_y;
  logic [9:0]      dx_d;
  logic [8:0]      dy_d;
  logic [7:0]      dpad;
  circle_t         circ;
  logic signed [10:0] cdx;
  logic signed [10:0] cdy;
  logic signed [21:0] sq_x;
  logic signed [21:0] sq_y;
  logic [22:0]     dist2;
  logic [7:0]      circ_bit;

  assign pop_o = (state_q == StIdle) && !q_stat_i.empty;
  assign start = (state_q == StMul);

  // Offset from the range minimum times the span; the product feeds a divider.
  assign scale_x = (cfg_i.x_max > cfg_i.x_min);
  assign scale_y = (cfg_i.y_max > cfg_i.y_min);
  assign diff_x  = $signed({job_q.raw_x[31], job_q.raw_x}) - $signed({17'd0, cfg_i.x_min});
  assign diff_y  = $signed({job_q.raw_y[31], job_q.raw_y}) - $signed({17'd0, cfg_i.y_min});
  assign prod_x  = 43'(diff_x) * 43'(XSpan);
  assign prod_y  = 43'(diff_y) * 43'(YSpan);

  // Without a usable range the raw value passes through a divide by one.
  always_comb begin
    if (scale_x) begin
      neg_x_d = prod_x[42];
      dvd_x   = prod_x[DivW-1:0];
      den_x   = cfg_i.x_max - cfg_i.x_min;
    end else begin
      neg_x_d = job_q.raw_x[31];
      dvd_x   = DivW'(job_q.raw_x[30:0]);
      den_x   = 16'd1;
    end
    if (scale_y) begin
      neg_y_d = prod_y[42];
      dvd_y   = prod_y[DivW-1:0];
      den_y   = cfg_i.y_max - cfg_i.y_min;
    end else begin
      neg_y_d = job_q.raw_y[31];
      dvd_y   = DivW'(job_q.raw_y[30:0]);
      den_y   = 16'd1;
    end
  end

  tegb_div u_div_x (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .dividend_i (dvd_x),
    .divisor_i  (den_x),
    .busy_o     (busy_x),
    .quotient_o (quo_x)
  );

  tegb_div u_div_y (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .dividend_i (dvd_y),
    .divisor_i  (den_y),
    .busy_o     (busy_y),
    .quotient_o (quo_y)
  );

  // Rotate to landscape and clamp. A negative numerator truncates toward zero,
  // so it lands on the low clamp of the scaled axis.
  always_comb begin
    if (neg_y_q) begin
      dx_d = DispXMax;
    end else if (quo_y >= DivW'(DispXMax)) begin
      dx_d = '0;
    end else begin
      dx_d = DispXMax - quo_y[9:0];
    end
    if (neg_x_q) begin
      dy_d = '0;
    end else if (quo_x >= DivW'(DispYMax)) begin
      dy_d = DispYMax;
    end else begin
      dy_d = quo_x[8:0];
    end
  end

  // D-pad directions.
  always_comb begin
    dpad = '0;
    if (dx_q >= DpadXLo && dx_q <= DpadXHi && dy_q >= DpadYLo && dy_q <= DpadYHi) begin
      if (dy_q < DpadUp) begin
        dpad[PadUpB] = 1'b1;
      end else if (dy_q > DpadDown) begin
        dpad[PadDownB] = 1'b1;
      end
      if (dx_q < DpadLeft) begin
        dpad[PadLeftB] = 1'b1;
      end else if (dx_q > DpadRight) begin
        dpad[PadRightB] = 1'b1;
      end
    end
  end

  // One round button per cycle.
  always_comb begin
    circ     = Circles[step_q];
    cdx      = $signed({1'b0, dx_q}) - $signed({1'b0, circ.cx});
    cdy      = $signed({2'b0, dy_q}) - $signed({2'b0, circ.cy});
    sq_x     = cdx * cdx;
    sq_y     = cdy * cdy;
    dist2    = 23'(unsigned'(sq_x)) + 23'(unsigned'(sq_y));
    circ_bit = '0;
    if (dist2 < 23'(circ.r2)) begin
      circ_bit[circ.pos] = 1'b1;
    end
  end

  assign out_valid_o    = (state_q == StOut);
  assign pad_bits_o     = pad_q;
  assign disp_x_o       = dx_q;
  assign disp_y_o       = dy_q;
  assign touch_active_o = act_q;

  // Sequencer and result registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      job_q   <= '0;
      neg_x_q <= 1'b0;
      neg_y_q <= 1'b0;
      dx_q    <= '0;
      dy_q    <= '0;
      pad_q   <= '0;
      act_q   <= 1'b0;
      step_q  <= '0;
    end else begin
      case (state_q)
        StIdle: begin
          if (!q_stat_i.empty) begin
            job_q <= job_i;
            if (job_i.active) begin
              state_q <= StMul;
            end else begin
              dx_q    <= '0;
              dy_q    <= '0;
              pad_q   <= '0;
              act_q   <= 1'b0;
              state_q <= StOut;
            end
          end
        end
        StMul: begin
          neg_x_q <= neg_x_d;
          neg_y_q <= neg_y_d;
          state_q <= StDiv;
        end
        StDiv: begin
          if (!busy_x && !busy_y) begin
            state_q <= StClamp;
          end
        end
        StClamp: begin
          dx_q    <= dx_d;
          dy_q    <= dy_d;
          pad_q   <= '0;
          act_q   <= 1'b1;
          step_q  <= '0;
          state_q <= StPad;
        end
        StPad: begin
          pad_q  <= pad_q | circ_bit | ((step_q == '0) ? dpad : 8'd0);
          step_q <= step_q + 1'b1;
          if (step_q == 2'd3) begin
            state_q <= StOut;
          end
        end
        StOut: begin
          if (!out_stall_i) begin
            state_q <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: sv/touch_event_to_gamepad_bits.sv
// A touched point goes through two serial dividers, one per axis. The back end
// finishes one sync result before it takes the next job from the queue; other
// events are taken one per cycle while the job queue has room.
// Reset: no position held, finger up, range registers zero, queue empty.
// ----------------------------------------------------------------------------
// touch_event_to_gamepad_bits
// Converts touch input events into an 8-bit gamepad word on each sync event.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module touch_event_to_gamepad_bits import tegb_pkg::*; #(
  parameter int unsigned FifoDepth = 4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [7:0]  cfg_index_i,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [15:0] mode_i,
  input  wire logic [15:0] event_code_i,
  input  wire logic [31:0] event_value_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       pad_bits_o,
  output logic [9:0]       disp_x_o,
  output logic [8:0]       disp_y_o,
  output logic             touch_active_o
);

  cfg_t    cfg_q;
  q_stat_t q_stat;
  logic    push;
  logic    pop;
  job_t    job_in;
  job_t    job_out;

  // Range registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgXMin: cfg_q.x_min <= cfg_wdata_i;
        CfgXMax: cfg_q.x_max <= cfg_wdata_i;
        CfgYMin: cfg_q.y_min <= cfg_wdata_i;
        CfgYMax: cfg_q.y_max <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  tegb_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .mode_i        (mode_i),
    .event_code_i  (event_code_i),
    .event_value_i (event_value_i),
    .q_stat_i      (q_stat),
    .push_o        (push),
    .job_o         (job_in)
  );

  tegb_fifo #(
    .Depth (FifoDepth),
    .Width ($bits(job_t))
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (job_in),
    .pop_i   (pop),
    .rdata_o (job_out),
    .stat_o  (q_stat)
  );

  tegb_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .q_stat_i       (q_stat),
    .job_i          (job_out),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .pad_bits_o     (pad_bits_o),
    .disp_x_o       (disp_x_o),
    .disp_y_o       (disp_y_o),
    .touch_active_o (touch_active_o)
  );

  // An idle result carries an all-zero payload.
  `ASSERT_IMPLY(a_idle_zero, clk_i, rst_ni, out_valid_o && !touch_active_o, pad_bits_o == 8'd0 && disp_x_o == 10'd0 && disp_y_o == 9'd0, "inactive result with nonzero payload")
  // Clamped coordinates stay on the display.
  `ASSERT_IMPLY(a_disp_range, clk_i, rst_ni, out_valid_o, disp_x_o <= DispXMax && disp_y_o <= DispYMax, "display point out of range")
  // Opposite D-pad directions are never pressed together.
  `ASSERT_IMPLY(a_dpad_excl, clk_i, rst_ni, out_valid_o, !(pad_bits_o[PadUpB] && pad_bits_o[PadDownB]) && !(pad_bits_o[PadLeftB] && pad_bits_o[PadRightB]), "opposite D-pad directions")
  // The front only pushes when the queue has room.
  `ASSERT_ALWAYS(a_no_overflow, clk_i, rst_ni, !(push && q_stat.full), "push into full queue")

endmodule

`default_nettype wire

FILE: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the touch event to gamepad converter. Touch events
// and sync transactions are driven with bursty, gapped timing while the
// result side stalls on its own schedule. Every sync result is checked
// against a predictor or typed expectation over several raw range settings.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top import tegb_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  // Codes that the block is expected to ignore.
  localparam logic [15:0] ModeUnused = 16'h0002;
  localparam logic [15:0] ModeAllOnes = 16'hffff;
  localparam logic [15:0] CodeUnused = 16'h002f;

  localparam int SettleCycles = 60;
  localparam int PhaseEvents = 200;
  localparam int NumPhases = 8;
  localparam int MaxReportLines = 200;

  typedef struct packed {
    logic [15:0] mode;
    logic [15:0] code;
    logic [31:0] value;
  } touch_event_t;

  typedef struct packed {
    logic [7:0] pad;
    logic [9:0] x;
    logic [8:0] y;
    logic       active;
  } gamepad_result_t;

  typedef struct packed {
    touch_event_t    ev;
    bit              typed;
    gamepad_result_t want;
  } stim_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [7:0]  cfg_index_i;
  logic [15:0] cfg_wdata_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [15:0] mode_i;
  logic [15:0] event_code_i;
  logic [31:0] event_value_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [7:0]  pad_bits_o;
  logic [9:0]  disp_x_o;
  logic [8:0]  disp_y_o;
  logic        touch_active_o;

  // Predictor state: held raw position, finger flag, last pad word, ranges.
  longint held_x;
  longint held_y;
  bit     finger;
  logic [7:0] last_pad_word;
  cfg_t   ranges;

  gamepad_result_t pending_results[$];
  stim_row_t       directed_rows[$];

  int mismatches;
  int events_sent;
  int results_seen;
  int touched_seen;
  int burst_left;
  logic [7:0] bits_seen;

  touch_event_to_gamepad_bits dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .mode_i        (mode_i),
    .event_code_i  (event_code_i),
    .event_value_i (event_value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .pad_bits_o    (pad_bits_o),
    .disp_x_o      (disp_x_o),
    .disp_y_o      (disp_y_o),
    .touch_active_o(touch_active_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Hard limit on the whole run.
  initial begin : watchdog
    #2_000_000;
    $display("Timeout with %0d results still pending.", pending_results.size());
    $display("FAIL");
    $finish;
  end

  // One line per mismatch, capped so a broken design cannot flood the log.
  task automatic report_mismatch(input string msg);
    if (mismatches < MaxReportLines) $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // Raw to panel scaling; the division truncates toward zero.
  function automatic longint scale_raw(input longint raw, input logic [15:0] lo,
                                       input logic [15:0] hi, input longint span);
    if (hi > lo) return ((raw - longint'(lo)) * span) / (longint'(hi) - longint'(lo));
    return raw;
  endfunction

  // D-pad box with a dead zone around its center, then the four round buttons.
  function automatic logic [7:0] buttons_at(input longint px, input longint py);
    logic [7:0] bits;
    bits = '0;
    if (px >= 35 && px <= 175 && py >= 105 && py <= 255) begin
      if (py - 180 < -22) bits[PadUpB] = 1'b1;
      else if (py - 180 > 22) bits[PadDownB] = 1'b1;
      if (px - 105 < -22) bits[PadLeftB] = 1'b1;
      else if (px - 105 > 22) bits[PadRightB] = 1'b1;
    end
    if ((px - 720) * (px - 720) + (py - 150) * (py - 150) < 2500) bits[PadA] = 1'b1;
    if ((px - 630) * (px - 630) + (py - 215) * (py - 215) < 2500) bits[PadB] = 1'b1;
    if ((px - 700) * (px - 700) + (py - 305) * (py - 305) < 784) bits[PadStart] = 1'b1;
    if ((px - 610) * (px - 610) + (py - 305) * (py - 305) < 784) bits[PadSelect] = 1'b1;
    return bits;
  endfunction

  // Updates the touch state for one event; returns 1 when a sync gives a result.
  function automatic bit predict_touch(input touch_event_t ev, output gamepad_result_t res);
    longint val;
    longint nx;
    longint ny;
    longint dx;
    longint dy;
    val = longint'($signed(ev.value));
    res = '0;
    if (ev.mode == ModeAbs) begin
      if (ev.code == CodeMtX || ev.code == CodeAbsX) held_x = val;
      else if (ev.code == CodeMtY || ev.code == CodeAbsY) held_y = val;
      else if (ev.code == CodeTrack) finger = (val >= 0);
      return 1'b0;
    end
    if (ev.mode == ModeKey) begin
      if (ev.code == CodeTouch) finger = (val != 0);
      return 1'b0;
    end
    if (ev.mode != ModeSync) return 1'b0;
    // Portrait scaling, rotation to landscape, then clamping.
    if (finger && held_x >= 0) begin
      nx = scale_raw(held_x, ranges.x_min, ranges.x_max, XSpan);
      ny = scale_raw(held_y, ranges.y_min, ranges.y_max, YSpan);
      dx = 799 - ny;
      if (dx < 0) dx = 0;
      else if (dx > 799) dx = 799;
      dy = nx;
      if (dy < 0) dy = 0;
      else if (dy > 339) dy = 339;
      res.pad = buttons_at(dx, dy);
      res.x = dx[9:0];
      res.y = dy[8:0];
      res.active = 1'b1;
    end
    last_pad_word = res.pad;
    return 1'b1;
  endfunction

  // Sends one transaction in bursts with random gaps; called and left at a
  // falling edge. A typed expectation replaces the predicted one.
  task automatic send_event(input logic [15:0] m, input logic [15:0] c,
                            input logic [31:0] v, input bit typed = 1'b0,
                            input gamepad_result_t want = '0);
    int unsigned gap;
    touch_event_t ev;
    gamepad_result_t res;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap != 0) begin
        in_valid_i = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    ev = '{mode: m, code: c, value: v};
    in_valid_i = 1'b1;
    mode_i = m;
    event_code_i = c;
    event_value_i = v;
    do @(posedge clk_i); while (in_stall_o);
    if (predict_touch(ev, res)) pending_results.push_back(typed ? want : res);
    if (m == ModeSync || (m == ModeKey && c == CodeTouch) ||
        (m == ModeAbs && (c == CodeAbsX || c == CodeMtX || c == CodeAbsY ||
                          c == CodeMtY || c == CodeTrack)))
      events_sent++;
    @(negedge clk_i);
  endtask

  // Stops sending until every expected result is back and the block is idle.
  task automatic drain_results();
    in_valid_i = 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_ranges(input cfg_t r);
    drain_results();
    cfg_we_i = 1'b1;
    cfg_index_i = CfgXMin;
    cfg_wdata_i = r.x_min;
    @(negedge clk_i);
    cfg_index_i = CfgXMax;
    cfg_wdata_i = r.x_max;
    @(negedge clk_i);
    cfg_index_i = CfgYMin;
    cfg_wdata_i = r.y_min;
    @(negedge clk_i);
    cfg_index_i = CfgYMax;
    cfg_wdata_i = r.y_max;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    ranges = r;
  endtask

  task automatic add_row(input logic [15:0] m, input logic [15:0] c, input logic [31:0] v,
                         input bit typed = 1'b0, input gamepad_result_t want = '0);
    directed_rows.push_back('{ev: '{mode: m, code: c, value: v}, typed: typed, want: want});
  endtask

  // Inverse scaling, so a chosen display point turns into a raw value.
  function automatic logic [31:0] raw_from_panel(input int n, input logic [15:0] lo,
                                                 input logic [15:0] hi, input int span);
    if (hi > lo)
      return 32'(longint'(lo) + (longint'(n) * (longint'(hi) - longint'(lo))) / span);
    return 32'(n);
  endfunction

  function automatic logic [31:0] uniform_raw(input logic [15:0] lo, input logic [15:0] hi);
    if (hi > lo) return $urandom_range(lo, hi);
    return $urandom_range(0, 1023);
  endfunction

  function automatic logic [15:0] axis_code(input bit is_y);
    if (is_y) return $urandom_range(0, 1) ? CodeMtY : CodeAbsY;
    return $urandom_range(0, 1) ? CodeMtX : CodeAbsX;
  endfunction

  // Mostly aims near a control, sometimes anywhere in range or fully random.
  task automatic pick_point(output logic [31:0] rx, output logic [31:0] ry);
    int tx;
    int ty;
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 60) begin
      case ($urandom_range(0, 4))
        0: begin
          tx = 25 + $urandom_range(0, 160);
          ty = 95 + $urandom_range(0, 170);
        end
        1: begin
          tx = 665 + $urandom_range(0, 110);
          ty = 95 + $urandom_range(0, 110);
        end
        2: begin
          tx = 575 + $urandom_range(0, 110);
          ty = 160 + $urandom_range(0, 110);
        end
        3: begin
          tx = 670 + $urandom_range(0, 60);
          ty = 275 + $urandom_range(0, 64);
        end
        default: begin
          tx = 580 + $urandom_range(0, 60);
          ty = 275 + $urandom_range(0, 64);
        end
      endcase
      rx = raw_from_panel(ty, ranges.x_min, ranges.x_max, XSpan);
      ry = raw_from_panel(799 - tx, ranges.y_min, ranges.y_max, YSpan);
    end else if (sel < 85) begin
      rx = uniform_raw(ranges.x_min, ranges.x_max);
      ry = uniform_raw(ranges.y_min, ranges.y_max);
    end else begin
      rx = $urandom();
      ry = $urandom();
    end
  endtask

  // One random gesture: touch and drag, key touch, bare sync, wild values or noise.
  task automatic touch_gesture();
    int unsigned kind;
    logic [31:0] rx;
    logic [31:0] ry;
    logic [31:0] v;
    kind = $urandom_range(0, 99);
    if (kind < 55) begin
      v = $urandom();
      v[31] = 1'b0;
      if ($urandom_range(0, 7) == 0) v = '0;
      send_event(ModeAbs, CodeTrack, v);
      pick_point(rx, ry);
      send_event(ModeAbs, axis_code(1'b0), rx);
      send_event(ModeAbs, axis_code(1'b1), ry);
      send_event(ModeSync, '0, '0);
      repeat ($urandom_range(0, 4)) begin
        pick_point(rx, ry);
        if ($urandom_range(0, 3) != 0) send_event(ModeAbs, axis_code(1'b0), rx);
        if ($urandom_range(0, 3) != 0) send_event(ModeAbs, axis_code(1'b1), ry);
        send_event(ModeSync, '0, '0);
      end
      if ($urandom_range(0, 2) != 0) begin
        v = $urandom();
        v[31] = 1'b1;
        send_event(ModeAbs, CodeTrack, v);
        send_event(ModeSync, '0, '0);
      end
    end else if (kind < 67) begin
      v = $urandom();
      if (v == '0) v = 32'd1;
      send_event(ModeKey, CodeTouch, v);
      pick_point(rx, ry);
      send_event(ModeAbs, axis_code(1'b0), rx);
      send_event(ModeAbs, axis_code(1'b1), ry);
      send_event(ModeSync, '0, '0);
      if ($urandom_range(0, 1) != 0) begin
        send_event(ModeKey, CodeTouch, '0);
        send_event(ModeSync, '0, '0);
      end
    end else if (kind < 77) begin
      send_event(ModeSync, 16'($urandom()), $urandom());
    end else if (kind < 85) begin
      send_event(ModeAbs, axis_code(1'b0), $urandom());
      send_event(ModeAbs, axis_code(1'b1), $urandom());
      send_event(ModeSync, '0, '0);
    end else begin
      // Noise: mostly ignored events, with known modes carrying odd codes.
      repeat ($urandom_range(1, 4)) begin
        case ($urandom_range(0, 2))
          0: send_event(ModeAbs, 16'($urandom()), $urandom());
          1: send_event(ModeKey, 16'($urandom()), $urandom());
          default: send_event(16'($urandom()), 16'($urandom()), $urandom());
        endcase
      end
    end
  endtask

  // Result side stalls in stretches: none, random, or mostly stalled.
  initial begin : result_stall
    int unsigned style;
    out_stall_i = 1'b0;
    forever begin
      style = $urandom_range(0, 2);
      repeat ($urandom_range(20, 200)) begin
        @(negedge clk_i);
        case (style)
          0: out_stall_i = 1'b0;
          1: out_stall_i = $urandom_range(0, 1);
          default: out_stall_i = ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk_i) begin : check_results
    gamepad_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected: pad %02h x %0d y %0d act %0b",
                                  pad_bits_o, disp_x_o, disp_y_o, touch_active_o));
      end else begin
        want = pending_results.pop_front();
        results_seen++;
        if (touch_active_o === 1'b1) touched_seen++;
        bits_seen |= pad_bits_o;
        if (pad_bits_o !== want.pad)
          report_mismatch($sformatf("pad_bits %02h, expected %02h", pad_bits_o, want.pad));
        if (disp_x_o !== want.x)
          report_mismatch($sformatf("disp_x %0d, expected %0d", disp_x_o, want.x));
        if (disp_y_o !== want.y)
          report_mismatch($sformatf("disp_y %0d, expected %0d", disp_y_o, want.y));
        if (touch_active_o !== want.active)
          report_mismatch($sformatf("touch_active %0b, expected %0b",
                                    touch_active_o, want.active));
      end
    end
  end

  initial begin : stimulus
    cfg_t r;
    int   phase;
    int   start_count;
    int   wait_cycles;
    int unsigned lo;

    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = '0;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    mode_i = '0;
    event_code_i = '0;
    event_value_i = '0;
    held_x = -1;
    held_y = -1;
    finger = 1'b0;
    last_pad_word = '0;
    ranges = '0;
    mismatches = 0;
    events_sent = 0;
    results_seen = 0;
    touched_seen = 0;
    burst_left = 0;
    bits_seen = '0;

    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed part, ranges at reset so raw values map to the panel unscaled.
    add_row(ModeSync, '0, '0, 1'b1, '{pad: 8'h00, x: 10'd0, y: 9'd0, active: 1'b0});
    add_row(ModeAbs, CodeMtX, 32'd180);
    add_row(ModeAbs, CodeTrack, 32'd0);
    // Y never written, so the held -1 lands past the right edge.
    add_row(ModeSync, '0, '0, 1'b1, '{pad: 8'h00, x: 10'd799, y: 9'd180, active: 1'b1});
    add_row(ModeAbs, CodeMtY, 32'd694);
    // Sync with junk code and value, point in the D-pad dead zone.
    add_row(ModeSync, 16'hffff, 32'hffff_ffff, 1'b1,
            '{pad: 8'h00, x: 10'd105, y: 9'd180, active: 1'b1});
    add_row(ModeAbs, CodeAbsY, 32'd764);
    add_row(ModeSync, '0, '0);
    add_row(ModeAbs, CodeAbsX, 32'd0);
    add_row(ModeSync, '0, '0);
    add_row(ModeAbs, CodeMtX, 32'h7fff_ffff);
    add_row(ModeAbs, CodeMtY, 32'h8000_0000);
    add_row(ModeSync, '0, '0, 1'b1, '{pad: 8'h00, x: 10'd799, y: 9'd339, active: 1'b1});
    add_row(ModeAbs, CodeAbsY, 32'h7fff_ffff);
    add_row(ModeSync, '0, '0, 1'b1, '{pad: 8'h00, x: 10'd0, y: 9'd339, active: 1'b1});
    // Negative x counts as no position.
    add_row(ModeAbs, CodeAbsX, 32'hffff_ffff);
    add_row(ModeSync, '0, '0, 1'b1, '0);
    add_row(ModeAbs, CodeMtX, 32'd150);
    add_row(ModeAbs, CodeMtY, 32'd79);
    add_row(ModeSync, '0, '0);
    add_row(ModeKey, CodeTouch, 32'd0);
    add_row(ModeSync, '0, '0, 1'b1, '0);
    add_row(ModeKey, CodeTouch, 32'h8000_0000);
    add_row(ModeSync, '0, '0);
    add_row(ModeAbs, CodeTrack, 32'hffff_ffff);
    add_row(ModeSync, '0, '0, 1'b1, '0);
    // Events with unknown types or codes leave the state alone.
    add_row(ModeUnused, CodeMtX, 32'd5);
    add_row(ModeAllOnes, CodeTrack, 32'd0);
    add_row(ModeAbs, CodeUnused, 32'd7);
    add_row(ModeKey, CodeMtX, 32'd9);
    add_row(ModeAbs, CodeTrack, 32'h7fff_ffff);
    add_row(ModeSync, '0, '0);
    add_row(ModeAbs, CodeMtX, 32'd215);
    add_row(ModeAbs, CodeMtY, 32'd169);
    add_row(ModeSync, '0, '0);
    add_row(ModeAbs, CodeMtX, 32'd305);
    add_row(ModeAbs, CodeMtY, 32'd99);
    add_row(ModeSync, '0, '0);
    add_row(ModeAbs, CodeMtY, 32'd189);
    add_row(ModeSync, '0, '0);

    foreach (directed_rows[i])
      send_event(directed_rows[i].ev.mode, directed_rows[i].ev.code,
                 directed_rows[i].ev.value, directed_rows[i].typed, directed_rows[i].want);

    // Random part, one range setting per phase; phase 0 keeps the reset ranges.
    for (phase = 0; phase < NumPhases; phase++) begin
      if (phase != 0) begin
        case (phase)
          1: r = '{x_min: 16'h0000, x_max: 16'hffff, y_min: 16'h0000, y_max: 16'hffff};
          2: r = '{x_min: 16'hffff, x_max: 16'h0000, y_min: 16'hffff, y_max: 16'h0000};
          3: r = '{x_min: 16'd100, x_max: 16'd4000, y_min: 16'd200, y_max: 16'd3900};
          4: r = '{x_min: 16'd1234, x_max: 16'd1234, y_min: 16'd5000, y_max: 16'd5000};
          5: begin
            lo = $urandom_range(0, 30000);
            r.x_min = 16'(lo);
            r.x_max = 16'(lo + $urandom_range(1, 35535));
            lo = $urandom_range(0, 30000);
            r.y_min = 16'(lo);
            r.y_max = 16'(lo + $urandom_range(1, 35535));
          end
          6: r = '{x_min: 16'h0000, x_max: 16'h0001, y_min: 16'hfffe, y_max: 16'hffff};
          default: r = {$urandom(), $urandom()};
        endcase
        write_ranges(r);
      end
      start_count = events_sent;
      while (events_sent - start_count < PhaseEvents) begin
        touch_gesture();
        if ($urandom_range(0, 49) == 0) drain_results();
      end
    end

    // Let the last results come back, then allow for trailing latency.
    in_valid_i = 1'b0;
    for (wait_cycles = 0; pending_results.size() != 0 && wait_cycles < 20000; wait_cycles++)
      @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d expected results never arrived", pending_results.size()));

    $display("Drove %0d touch and sync events over %0d raw range settings.",
             events_sent, NumPhases);
    $display("Checked %0d sync results, %0d with a touch; pad bits seen set: %08b.",
             results_seen, touched_seen, bits_seen);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
